FILE: hw/rtl/jtec_pkg.sv
// shared types, constants and helpers of the text to euc-jp converter
package jtec_pkg;

    localparam int RUN_MAX    = 6;
    localparam int RUN_CNT_W  = $clog2(RUN_MAX + 1);
    localparam int RUN_IDX_W  = $clog2(RUN_MAX);
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam logic [1:0] ENC_JIS  = 2'd0;
    localparam logic [1:0] ENC_EUC  = 2'd1;
    localparam logic [1:0] ENC_SJIS = 2'd2;

    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_ESC    = 8'h1B;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_PAREN  = 8'h28;
    localparam logic [7:0] CH_AT     = 8'h40;
    localparam logic [7:0] CH_B      = 8'h42;
    localparam logic [7:0] CH_D      = 8'h44;
    localparam logic [7:0] CH_H      = 8'h48;
    localparam logic [7:0] CH_I      = 8'h49;
    localparam logic [7:0] CH_J      = 8'h4A;
    localparam logic [7:0] HIGH_BIT  = 8'h80;
    localparam logic [7:0] SS2       = 8'h8E;
    localparam logic [7:0] KANA_LO   = 8'hA1;
    localparam logic [7:0] KANA_HI   = 8'hDF;
    localparam logic [7:0] TRAIL_OFS = 8'h1F;
    localparam logic [7:0] TRAIL_HI  = 8'h7E;
    localparam logic [7:0] LEAD_OFS1 = 8'h81;
    localparam logic [7:0] LEAD_MID  = 8'h9F;
    localparam logic [7:0] LEAD_OFS2 = 8'hC1;
    localparam logic [7:0] ROW_OFS   = 8'h21;
    localparam logic [7:0] TRAIL_LO  = 8'h40;
    localparam logic [7:0] TRAIL_TOP = 8'hFC;
    localparam logic [7:0] LEAD2_LO  = 8'hE0;
    localparam logic [7:0] LEAD2_HI  = 8'hEF;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_text;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
    } t_out_item;

    typedef struct packed {
        logic [RUN_MAX-1:0][7:0] bytes;
        logic [RUN_CNT_W-1:0]    count;
    } t_run;

    function automatic t_run run_push(t_run r, logic [7:0] x);
        t_run q;
        q = r;
        if (q.count < RUN_CNT_W'(RUN_MAX)) begin
            q.bytes[RUN_IDX_W'(q.count)] = x;
            q.count = q.count + 1'b1;
        end
        return q;
    endfunction

endpackage

FILE: hw/rtl/jtec_front.sv
// front end: decodes each input byte into a run of euc-jp bytes
module jtec_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_data,
    input  logic                i_accept,
    input  jtec_pkg::t_in_item  i_item,
    output logic                o_wr,
    output jtec_pkg::t_run      o_run
);

    logic [1:0] r_enc;
    logic       r_dbm, n_dbm;
    logic [7:0] r_esc [3];
    logic [7:0] n_esc [3];
    logic [1:0] r_cnt, n_cnt;
    logic       r_pcr, n_pcr;
    logic [7:0] r_lead, n_lead;
    logic       r_lead_v, n_lead_v;
    jtec_pkg::t_run w_run;

    always_comb begin
        logic [7:0] b;
        logic       brk;
        logic       do_fresh;
        logic       do_line;
        logic       fresh_p;
        logic       sj_done;
        logic       low;
        logic [7:0] t;
        logic [7:0] l;
        b        = i_item.data_byte;
        brk      = 1'b0;
        do_fresh = 1'b0;
        do_line  = 1'b0;
        fresh_p  = r_pcr;
        sj_done  = 1'b0;
        low      = 1'b0;
        t        = b;
        l        = r_lead;
        w_run    = '0;
        n_dbm    = r_dbm;
        n_esc    = r_esc;
        n_cnt    = r_cnt;
        n_pcr    = 1'b0;
        n_lead   = r_lead;
        n_lead_v = r_lead_v;

        if (r_enc == jtec_pkg::ENC_JIS) begin
            if (r_cnt == 2'd0) begin
                do_fresh = 1'b1;
            end else if (!r_dbm) begin
                if (r_cnt == 2'd1 && b == jtec_pkg::CH_DOLLAR) begin
                    n_esc[1] = b;
                    n_cnt    = 2'd2;
                end else if (r_cnt == 2'd2 && b == jtec_pkg::CH_PAREN) begin
                    n_esc[2] = b;
                    n_cnt    = 2'd3;
                end else if (r_cnt >= 2'd2 && (b == jtec_pkg::CH_AT ||
                             b == jtec_pkg::CH_B || b == jtec_pkg::CH_D)) begin
                    n_dbm = 1'b1;
                    n_cnt = 2'd0;
                end else begin
                    brk = 1'b1;
                end
            end else begin
                if (r_cnt == 2'd1 && b == jtec_pkg::CH_PAREN) begin
                    n_esc[1] = b;
                    n_cnt    = 2'd2;
                end else if (r_cnt == 2'd2 && (b == jtec_pkg::CH_J || b == jtec_pkg::CH_H ||
                             b == jtec_pkg::CH_B || b == jtec_pkg::CH_I)) begin
                    n_dbm = 1'b0;
                    n_cnt = 2'd0;
                end else begin
                    brk = 1'b1;
                end
            end
            if (brk) begin
                for (int i = 0; i < 3; i++) begin
                    if (2'(i) < r_cnt) begin
                        w_run = jtec_pkg::run_push(w_run, r_esc[i] | {r_dbm, 7'b0});
                    end
                end
                n_cnt    = 2'd0;
                do_fresh = 1'b1;
                fresh_p  = 1'b0;
            end
            if (do_fresh) begin
                if (!b[7]) begin
                    if (b == jtec_pkg::CH_ESC) begin
                        n_esc[0] = b;
                        n_cnt    = 2'd1;
                    end else if (r_dbm) begin
                        w_run = jtec_pkg::run_push(w_run, b | jtec_pkg::HIGH_BIT);
                    end else begin
                        do_line = 1'b1;
                    end
                end else if (b >= jtec_pkg::KANA_LO && b <= jtec_pkg::KANA_HI) begin
                    w_run = jtec_pkg::run_push(w_run, jtec_pkg::SS2);
                    w_run = jtec_pkg::run_push(w_run, b);
                end
            end
        end else if (r_enc == jtec_pkg::ENC_SJIS) begin
            if (r_lead_v) begin
                n_lead_v = 1'b0;
                if ((b >= jtec_pkg::TRAIL_LO && b <= jtec_pkg::TRAIL_HI) ||
                    (b >= jtec_pkg::HIGH_BIT && b <= jtec_pkg::TRAIL_TOP)) begin
                    if (b < jtec_pkg::LEAD_MID) begin
                        low = 1'b0;
                        t   = b[7] ? (b - 8'd1 - jtec_pkg::TRAIL_OFS) : (b - jtec_pkg::TRAIL_OFS);
                    end else begin
                        low = 1'b1;
                        t   = b - jtec_pkg::TRAIL_HI;
                    end
                    if (r_lead <= jtec_pkg::LEAD_MID) begin
                        l = r_lead - jtec_pkg::LEAD_OFS1;
                    end else begin
                        l = r_lead - jtec_pkg::LEAD_OFS2;
                    end
                    l = {l[6:0], 1'b0} + jtec_pkg::ROW_OFS + {7'b0, low};
                    w_run   = jtec_pkg::run_push(w_run, l | jtec_pkg::HIGH_BIT);
                    w_run   = jtec_pkg::run_push(w_run, t | jtec_pkg::HIGH_BIT);
                    sj_done = 1'b1;
                end
            end
            if (!sj_done) begin
                if ((b >= jtec_pkg::LEAD_OFS1 && b <= jtec_pkg::LEAD_MID) ||
                    (b >= jtec_pkg::LEAD2_LO && b <= jtec_pkg::LEAD2_HI)) begin
                    n_lead   = b;
                    n_lead_v = 1'b1;
                end else if (b >= jtec_pkg::KANA_LO && b <= jtec_pkg::KANA_HI) begin
                    w_run = jtec_pkg::run_push(w_run, jtec_pkg::SS2);
                    w_run = jtec_pkg::run_push(w_run, b);
                end else if (!b[7]) begin
                    do_line = 1'b1;
                end
            end
        end else begin
            do_line = 1'b1;
        end

        if (do_line) begin
            if (b == jtec_pkg::CH_LF && fresh_p) begin
                w_run = w_run;
            end else if (b == jtec_pkg::CH_CR) begin
                w_run = jtec_pkg::run_push(w_run, jtec_pkg::CH_LF);
                n_pcr = 1'b1;
            end else begin
                w_run = jtec_pkg::run_push(w_run, b);
            end
        end

        if (i_item.end_of_text) begin
            if (r_enc == jtec_pkg::ENC_JIS) begin
                for (int i = 0; i < 3; i++) begin
                    if (2'(i) < n_cnt) begin
                        w_run = jtec_pkg::run_push(w_run, n_esc[i] | {n_dbm, 7'b0});
                    end
                end
            end
            n_dbm    = 1'b0;
            n_cnt    = 2'd0;
            n_pcr    = 1'b0;
            n_lead_v = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enc    <= jtec_pkg::ENC_JIS;
            r_dbm    <= 1'b0;
            r_cnt    <= 2'd0;
            r_pcr    <= 1'b0;
            r_lead_v <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_enc <= i_cfg_data;
            end
            if (i_accept) begin
                r_dbm    <= n_dbm;
                r_cnt    <= n_cnt;
                r_pcr    <= n_pcr;
                r_lead_v <= n_lead_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_esc  <= n_esc;
            r_lead <= n_lead;
        end
    end

    assign o_wr  = i_accept && (w_run.count != '0);
    assign o_run = w_run;

endmodule

FILE: hw/rtl/jtec_fifo.sv
// short queue of decoded runs between front and back end
module jtec_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr,
    input  jtec_pkg::t_run i_wdata,
    input  logic           i_rd,
    output jtec_pkg::t_run o_rdata,
    output logic           o_full,
    output logic           o_empty
);

    jtec_pkg::t_run                  r_mem [jtec_pkg::FIFO_DEPTH];
    logic [jtec_pkg::FIFO_PTR_W-1:0] r_wp;
    logic [jtec_pkg::FIFO_PTR_W-1:0] r_rp;
    logic [jtec_pkg::FIFO_CNT_W-1:0] r_cnt;
    logic                            w_wr;
    logic                            w_rd;

    assign o_full  = (r_cnt == jtec_pkg::FIFO_CNT_W'(jtec_pkg::FIFO_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign w_wr    = i_wr && !o_full;
    assign w_rd    = i_rd && !o_empty;
    assign o_rdata = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_rd) begin
                r_rp <= r_rp + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

endmodule

FILE: hw/rtl/jtec_back.sv
// back end: plays out each run one byte per item
module jtec_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  jtec_pkg::t_run      i_run,
    input  logic                i_run_empty,
    output logic                o_run_rd,
    output logic                o_empty,
    input  logic                i_pop,
    output jtec_pkg::t_out_item o_item
);

    logic                           r_busy;
    jtec_pkg::t_run                 r_ent;
    logic [jtec_pkg::RUN_IDX_W-1:0] r_idx;
    logic                           w_last;
    logic                           w_take;
    logic                           w_load;

    assign w_last   = (r_idx == jtec_pkg::RUN_IDX_W'(r_ent.count - 1'b1));
    assign w_take   = r_busy && i_pop;
    assign w_load   = (!r_busy || (w_take && w_last)) && !i_run_empty;
    assign o_run_rd = w_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (w_load) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (w_take) begin
            if (w_last) begin
                r_busy <= 1'b0;
            end
            r_idx <= r_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_ent <= i_run;
        end
    end

    assign o_empty            = !r_busy;
    assign o_item.out_byte    = r_ent.bytes[r_idx];
    assign o_item.last_of_run = w_last;

endmodule

FILE: hw/rtl/japanese_text_to_euc_converter_unit.sv
// top level of the jis / euc / shift_jis to euc-jp byte converter
//
//  port group   direction  handshake          payload
//  input        in         push / full        i_item (data_byte, end_of_text)
//  result       out        empty / pop        o_item (out_byte, last_of_run)
//  config       in         i_cfg_we           i_cfg_data (source_encoding)
//
// an input byte is decoded in the cycle it is accepted; one item per cycle while
// the four-entry run queue has room
// results leave the back end one byte per cycle while pop is held, so a byte making n outputs
// takes n pops on the result side
// full follows the run queue only; a stalled pop backs up into the queue
// synchronous active-low reset empties the queue and back end, clears the decode flags and selects jis
module japanese_text_to_euc_converter_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  jtec_pkg::t_in_item  i_item,
    output logic                empty,
    input  logic                pop,
    output jtec_pkg::t_out_item o_item,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_data
);

    logic           w_accept;
    logic           w_wr;
    jtec_pkg::t_run w_wrun;
    jtec_pkg::t_run w_rrun;
    logic           w_rd;
    logic           w_qempty;

    assign w_accept = push && !full;

    jtec_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_accept   (w_accept),
        .i_item     (i_item),
        .o_wr       (w_wr),
        .o_run      (w_wrun)
    );

    jtec_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_wr),
        .i_wdata (w_wrun),
        .i_rd    (w_rd),
        .o_rdata (w_rrun),
        .o_full  (full),
        .o_empty (w_qempty)
    );

    jtec_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_run       (w_rrun),
        .i_run_empty (w_qempty),
        .o_run_rd    (w_rd),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_item      (o_item)
    );

endmodule

FILE: hw/rtl/jtec_checker.sv
// port-level checks of the converter and their attachment to the top level
module jtec_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                full,
    input logic                empty,
    input logic                pop,
    input jtec_pkg::t_out_item o_item
);

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty && !full)
        else $error("not empty after reset");

    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && pop && !o_item.last_of_run) |=> !empty)
        else $error("run broken before its last byte");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_item)))
        else $error("stalled item changed");

    a_full_needs_backlog: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($rose(full)) |-> !empty)
        else $error("queue full while nothing offered");

endmodule

bind japanese_text_to_euc_converter_unit jtec_checker u_jtec_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .full    (full),
    .empty   (empty),
    .pop     (pop),
    .o_item  (o_item)
);
